FILE: sv/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared widths and types for the rational divide-and-reduce block.
// ----------------------------------------------------------------------------
package rdr_pkg;

	localparam int PART_BITS = 64;
	localparam int HALF_BITS = PART_BITS / 2;
	localparam int WIDE_BITS = 2 * PART_BITS;
	localparam int SHIFT_CNT_BITS = $clog2(WIDE_BITS);

	typedef logic [PART_BITS-1:0] part_t;
	typedef logic [WIDE_BITS-1:0] wide_t;

endpackage

FILE: sv/rdr_mul.sv
// ----------------------------------------------------------------------------
// rdr_mul
// Double-width product built from four half-width partial products through
// one multiplier, accumulated one by one.
// ----------------------------------------------------------------------------
module rdr_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rdr_pkg::part_t a,
	input  rdr_pkg::part_t b,
	output logic           done,
	output rdr_pkg::wide_t product
);

	rdr_pkg::part_t                  a_q;
	rdr_pkg::part_t                  b_q;
	rdr_pkg::wide_t                  acc_q;
	logic [2:0]                      cnt_q;
	logic                            active_q;
	logic                            done_q;
	rdr_pkg::part_t                  prod_s1;
	logic [1:0]                      sh_s1;
	logic                            pv_s1;
	logic [rdr_pkg::HALF_BITS-1:0]   a_half;
	logic [rdr_pkg::HALF_BITS-1:0]   b_half;
	rdr_pkg::wide_t                  prod_ext;
	rdr_pkg::wide_t                  addend;

	assign a_half = cnt_q[0] ? a_q[rdr_pkg::PART_BITS-1:rdr_pkg::HALF_BITS]
	                         : a_q[rdr_pkg::HALF_BITS-1:0];
	assign b_half = cnt_q[1] ? b_q[rdr_pkg::PART_BITS-1:rdr_pkg::HALF_BITS]
	                         : b_q[rdr_pkg::HALF_BITS-1:0];
	assign prod_ext = {{(rdr_pkg::WIDE_BITS-rdr_pkg::PART_BITS){1'b0}}, prod_s1};

	always_comb begin
		unique case (sh_s1)
			2'd0:    addend = prod_ext;
			2'd1:    addend = prod_ext << rdr_pkg::HALF_BITS;
			default: addend = prod_ext << rdr_pkg::PART_BITS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			pv_s1    <= 1'b0;
			cnt_q    <= '0;
			a_q      <= '0;
			b_q      <= '0;
			acc_q    <= '0;
			prod_s1  <= '0;
			sh_s1    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q      <= a;
				b_q      <= b;
				acc_q    <= '0;
				cnt_q    <= '0;
				pv_s1    <= 1'b0;
				active_q <= 1'b1;
			end else if (active_q) begin
				prod_s1 <= rdr_pkg::part_t'(a_half * b_half);
				sh_s1   <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
				pv_s1   <= !cnt_q[2];
				if (pv_s1)
					acc_q <= acc_q + addend;
				if (cnt_q[2]) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

FILE: sv/rdr_gcd.sv
// ----------------------------------------------------------------------------
// rdr_gcd
// Binary greatest common divisor of two double-width values; one shift,
// compare/swap or subtract per cycle.
// ----------------------------------------------------------------------------
module rdr_gcd (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rdr_pkg::wide_t a,
	input  rdr_pkg::wide_t b,
	output logic           done,
	output rdr_pkg::wide_t gcd
);

	typedef enum logic [6:0] {
		G_IDLE = 7'b0000001,
		G_ZERO = 7'b0000010,
		G_TWOS = 7'b0000100,
		G_AODD = 7'b0001000,
		G_LOOP = 7'b0010000,
		G_SUB  = 7'b0100000,
		G_SHL  = 7'b1000000
	} gcd_state_t;

	gcd_state_t                          state_q;
	rdr_pkg::wide_t                      a_q;
	rdr_pkg::wide_t                      b_q;
	logic [rdr_pkg::SHIFT_CNT_BITS-1:0]  k_q;
	logic                                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						k_q     <= '0;
						state_q <= G_ZERO;
					end
				end
				G_ZERO: begin
					if (a_q == '0) begin
						a_q     <= b_q;
						state_q <= G_SHL;
					end else if (b_q == '0) begin
						state_q <= G_SHL;
					end else begin
						state_q <= G_TWOS;
					end
				end
				G_TWOS: begin
					if (!(a_q[0] | b_q[0])) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= G_AODD;
					end
				end
				G_AODD: begin
					if (!a_q[0])
						a_q <= a_q >> 1;
					else
						state_q <= G_LOOP;
				end
				G_LOOP: begin
					if (b_q == '0) begin
						state_q <= G_SHL;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else begin
						if (a_q >= b_q) begin
							a_q <= b_q;
							b_q <= a_q;
						end
						state_q <= G_SUB;
					end
				end
				G_SUB: begin
					b_q     <= b_q - a_q;
					state_q <= G_LOOP;
				end
				G_SHL: begin
					if (k_q != '0) begin
						a_q <= a_q << 1;
						k_q <= k_q - 1'b1;
					end else begin
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign gcd  = a_q;

endmodule

FILE: sv/rdr_div.sv
// ----------------------------------------------------------------------------
// rdr_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdr_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rdr_pkg::wide_t dividend,
	input  rdr_pkg::wide_t divisor,
	output logic           done,
	output rdr_pkg::wide_t quotient
);

	rdr_pkg::wide_t                      n_q;
	rdr_pkg::wide_t                      r_q;
	rdr_pkg::wide_t                      g_q;
	logic [rdr_pkg::SHIFT_CNT_BITS-1:0]  cnt_q;
	logic                                active_q;
	logic                                done_q;
	logic [rdr_pkg::WIDE_BITS:0]         rs;
	logic [rdr_pkg::WIDE_BITS+1:0]       diff;
	logic                                ge;

	assign rs   = {r_q, n_q[rdr_pkg::WIDE_BITS-1]};
	assign diff = {1'b0, rs} - {2'b00, g_q};
	assign ge   = !diff[rdr_pkg::WIDE_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			n_q      <= '0;
			r_q      <= '0;
			g_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q      <= dividend;
				g_q      <= divisor;
				r_q      <= '0;
				cnt_q    <= '0;
				active_q <= 1'b1;
			end else if (active_q) begin
				r_q   <= ge ? diff[rdr_pkg::WIDE_BITS-1:0] : rs[rdr_pkg::WIDE_BITS-1:0];
				n_q   <= {n_q[rdr_pkg::WIDE_BITS-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rdr_pkg::SHIFT_CNT_BITS'(rdr_pkg::WIDE_BITS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = n_q;

endmodule

FILE: sv/rational_divide_reduce.sv
// ----------------------------------------------------------------------------
// rational_divide_reduce
// Divides x_num/x_den by y_num/y_den and reduces the quotient by its gcd.
// ----------------------------------------------------------------------------
// Raise start with the four operands while busy is low; the operands are
// captured on that edge. busy stays high until the result is out. The result
// appears on result_num, result_den and fits with done high for exactly one
// cycle and is held until the next result; there is no back-pressure, so the
// receiver must take it in that cycle. A transfer forms the two cross
// products through one shared half-width multiplier, then runs a
// data-dependent binary gcd loop of one shift, swap or subtract per cycle
// (the variable part, which also restores common factors of two), and then,
// unless both cross products are zero, the two restoring divisions through
// one shared divider. fits is 0 and both parts are 0 when a reduced part
// exceeds 64 bits or both cross products are zero.
// ----------------------------------------------------------------------------
module rational_divide_reduce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] x_num,
	input  logic [63:0] x_den,
	input  logic [63:0] y_num,
	input  logic [63:0] y_den,
	output logic        done,
	output logic [63:0] result_num,
	output logic [63:0] result_den,
	output logic        fits
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MULN = 6'b000010,
		S_MULD = 6'b000100,
		S_GCD  = 6'b001000,
		S_DIVN = 6'b010000,
		S_DIVD = 6'b100000
	} seq_state_t;

	seq_state_t      state_q;
	logic            kick_q;
	rdr_pkg::part_t  xn_q;
	rdr_pkg::part_t  xd_q;
	rdr_pkg::part_t  yn_q;
	rdr_pkg::part_t  yd_q;
	rdr_pkg::wide_t  n_q;
	rdr_pkg::wide_t  d_q;
	rdr_pkg::wide_t  g_q;
	logic [63:0]     res_num_q;
	logic [63:0]     res_den_q;
	logic            fits_q;
	logic            done_q;

	rdr_pkg::part_t  mul_a;
	rdr_pkg::part_t  mul_b;
	logic            mul_start;
	logic            mul_done;
	rdr_pkg::wide_t  mul_p;
	logic            gcd_start;
	logic            gcd_done;
	rdr_pkg::wide_t  gcd_g;
	logic            div_start;
	logic            div_done;
	rdr_pkg::wide_t  div_n;
	rdr_pkg::wide_t  div_q;
	logic            fit_ok;

	assign mul_a     = (state_q == S_MULN) ? xn_q : xd_q;
	assign mul_b     = (state_q == S_MULN) ? yd_q : yn_q;
	assign mul_start = kick_q && (state_q == S_MULN || state_q == S_MULD);
	assign gcd_start = kick_q && (state_q == S_GCD);
	assign div_start = kick_q && (state_q == S_DIVN || state_q == S_DIVD);
	assign div_n     = (state_q == S_DIVN) ? n_q : d_q;

	assign fit_ok = (n_q[rdr_pkg::WIDE_BITS-1:rdr_pkg::PART_BITS] == '0) &&
	                (div_q[rdr_pkg::WIDE_BITS-1:rdr_pkg::PART_BITS] == '0);

	rdr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	rdr_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (n_q),
		.b      (d_q),
		.done   (gcd_done),
		.gcd    (gcd_g)
	);

	rdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kick_q    <= 1'b0;
			done_q    <= 1'b0;
			fits_q    <= 1'b0;
			res_num_q <= '0;
			res_den_q <= '0;
			xn_q      <= '0;
			xd_q      <= '0;
			yn_q      <= '0;
			yd_q      <= '0;
			n_q       <= '0;
			d_q       <= '0;
			g_q       <= '0;
		end else begin
			kick_q <= 1'b0;
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						xn_q    <= x_num[rdr_pkg::PART_BITS-1:0];
						xd_q    <= x_den[rdr_pkg::PART_BITS-1:0];
						yn_q    <= y_num[rdr_pkg::PART_BITS-1:0];
						yd_q    <= y_den[rdr_pkg::PART_BITS-1:0];
						kick_q  <= 1'b1;
						state_q <= S_MULN;
					end
				end
				S_MULN: begin
					if (mul_done) begin
						n_q     <= mul_p;
						kick_q  <= 1'b1;
						state_q <= S_MULD;
					end
				end
				S_MULD: begin
					if (mul_done) begin
						d_q     <= mul_p;
						kick_q  <= 1'b1;
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (gcd_done) begin
						g_q <= gcd_g;
						if (gcd_g == '0) begin
							res_num_q <= '0;
							res_den_q <= '0;
							fits_q    <= 1'b0;
							done_q    <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							kick_q  <= 1'b1;
							state_q <= S_DIVN;
						end
					end
				end
				S_DIVN: begin
					if (div_done) begin
						n_q     <= div_q;
						kick_q  <= 1'b1;
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_done) begin
						fits_q    <= fit_ok;
						res_num_q <= fit_ok ? 64'(n_q[rdr_pkg::PART_BITS-1:0]) : '0;
						res_den_q <= fit_ok ? 64'(div_q[rdr_pkg::PART_BITS-1:0]) : '0;
						done_q    <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign result_num = res_num_q;
	assign result_den = res_den_q;
	assign fits       = fits_q;

endmodule

FILE: tb/rational_divide_reduce_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_divide_reduce_test
// Self-checking bench for the rational divide-and-reduce block.
// ----------------------------------------------------------------------------
// Operand sets go in through the start/busy handshake. Each accepted set is
// run through a behavioral model (wide cross products, Euclid gcd, overflow
// check) and the expected quotient is queued. Every done strobe is checked
// against the oldest queued quotient. Directed cases cover field extremes,
// zero products and overflow; random cases cover reducible, equal, full-width,
// mixed-length and power-of-two operands, mostly with random sender idle time.
// ----------------------------------------------------------------------------
module rational_divide_reduce_test;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1000;
	localparam logic [63:0] PART_MASK = {64{1'b1}} >> (64 - rdr_pkg::PART_BITS);
	localparam logic [63:0] ALL_ONES = {64{1'b1}};

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		logic        fits;
	} quotient_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [63:0] x_num = '0;
	logic [63:0] x_den = '0;
	logic [63:0] y_num = '0;
	logic [63:0] y_den = '0;
	logic        busy;
	logic        done;
	logic [63:0] result_num;
	logic [63:0] result_den;
	logic        fits;

	quotient_t pending_quotients[$];
	quotient_t want;
	int        errors = 0;
	int        sets_sent = 0;
	int        quotients_seen = 0;
	int        reduced_seen = 0;
	int        idle_count = 0;
	bit        sender_idles = 1'b1;

	rational_divide_reduce uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.x_num(x_num),
		.x_den(x_den),
		.y_num(y_num),
		.y_den(y_den),
		.done(done),
		.result_num(result_num),
		.result_den(result_den),
		.fits(fits)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic rdr_pkg::wide_t wide_gcd(input rdr_pkg::wide_t a,
			input rdr_pkg::wide_t b);
		rdr_pkg::wide_t t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic quotient_t predict_quotient(input logic [63:0] xn, xd, yn, yd);
		rdr_pkg::wide_t n, d, g, qn, qd;
		quotient_t q;
		n = rdr_pkg::wide_t'(xn & PART_MASK) * rdr_pkg::wide_t'(yd & PART_MASK);
		d = rdr_pkg::wide_t'(xd & PART_MASK) * rdr_pkg::wide_t'(yn & PART_MASK);
		g = wide_gcd(n, d);
		q = '{num: '0, den: '0, fits: 1'b0};
		if (g != 0) begin
			qn = n / g;
			qd = d / g;
			if ((qn >> rdr_pkg::PART_BITS) == 0 && (qd >> rdr_pkg::PART_BITS) == 0) begin
				q.num = qn[63:0];
				q.den = qd[63:0];
				q.fits = 1'b1;
			end
		end
		return q;
	endfunction

	// nonzero value of at most nbits significant bits
	function automatic logic [63:0] rand_bits(input int nbits);
		logic [63:0] v;
		v = {$urandom, $urandom} >> (64 - nbits);
		if (v == 0)
			v = 64'd1;
		return v;
	endfunction

	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_idles || r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 8);
		if (r < 97)
			return $urandom_range(9, 300);
		return $urandom_range(301, 1200);
	endfunction

	task automatic transfer_operands(input logic [63:0] xn, xd, yn, yd);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		x_num <= xn;
		x_den <= xd;
		y_num <= yn;
		y_den <= yd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_quotients.insert(pending_quotients.size(), predict_quotient(xn, xd, yn, yd));
		sets_sent++;
	endtask

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			quotients_seen++;
			if (fits)
				reduced_seen++;
			if (pending_quotients.size() == 0) begin
				flag_error($sformatf("unexpected result %0h/%0h fits %b",
					result_num, result_den, fits));
			end else begin
				want = pending_quotients.pop_front();
				if (result_num !== want.num || result_den !== want.den
						|| fits !== want.fits)
					flag_error($sformatf("mismatch: want %0h/%0h fits %b, got %0h/%0h fits %b",
						want.num, want.den, want.fits, result_num, result_den, fits));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("%t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic test_extremes();
		transfer_operands(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		transfer_operands(64'd1, 64'd1, 64'd1, 64'd1);
		transfer_operands(ALL_ONES, 64'd1, 64'd1, 64'd1);
		transfer_operands(64'd1, ALL_ONES, 64'd1, 64'd1);
		transfer_operands(64'd1, 64'd1, ALL_ONES, 64'd1);
		transfer_operands(64'd1, 64'd1, 64'd1, ALL_ONES);
		transfer_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		transfer_operands(64'h8000_0000_0000_0000, 64'd2, 64'd4, 64'h4000_0000_0000_0000);
		transfer_operands(ALL_ONES - 1, ALL_ONES, ALL_ONES, ALL_ONES - 1);
	endtask

	task automatic test_overflow();
		transfer_operands(ALL_ONES, 64'd1, 64'd1, ALL_ONES);
		transfer_operands(64'd1, ALL_ONES, ALL_ONES, 64'd1);
		transfer_operands(64'h8000_0000_0000_0000, 64'd1, 64'd1, 64'd2);
		transfer_operands(ALL_ONES, 64'd3, 64'd5, ALL_ONES - 2);
	endtask

	// zero numerator product, zero denominator product, both zero
	task automatic test_zero_products();
		transfer_operands(64'd0, 64'd5, 64'd7, 64'd3);
		transfer_operands(64'd4, 64'd3, 64'd7, 64'd0);
		transfer_operands(64'd4, 64'd0, 64'd7, 64'd3);
		transfer_operands(64'd4, 64'd3, 64'd0, 64'd5);
		transfer_operands(64'd0, 64'd0, 64'd7, 64'd3);
		transfer_operands(64'd0, 64'd3, 64'd0, 64'd5);
		transfer_operands(ALL_ONES, 64'd0, 64'd0, ALL_ONES);
	endtask

	task automatic test_reducible(input int count);
		logic [63:0] f;
		repeat (count) begin
			f = rand_bits($urandom_range(1, 32));
			transfer_operands(f * rand_bits($urandom_range(1, 32)),
				rand_bits($urandom_range(1, 32)),
				f * rand_bits($urandom_range(1, 32)),
				rand_bits($urandom_range(1, 32)));
		end
	endtask

	task automatic test_equal_fractions(input int count);
		logic [63:0] a, b, s, t;
		repeat (count) begin
			a = rand_bits($urandom_range(1, 32));
			b = rand_bits($urandom_range(1, 32));
			s = rand_bits($urandom_range(1, 32));
			t = rand_bits($urandom_range(1, 32));
			transfer_operands(a * s, b * s, a * t, b * t);
		end
	endtask

	task automatic test_full_width(input int count);
		repeat (count)
			transfer_operands(rand_bits(64), rand_bits(64), rand_bits(64), rand_bits(64));
	endtask

	task automatic test_mixed_lengths(input int count);
		repeat (count)
			transfer_operands(rand_bits($urandom_range(1, 64)), rand_bits($urandom_range(1, 64)),
				rand_bits($urandom_range(1, 64)), rand_bits($urandom_range(1, 64)));
	endtask

	task automatic test_powers_of_two(input int count);
		repeat (count)
			transfer_operands(rand_bits($urandom_range(1, 16)) << $urandom_range(0, 47),
				64'd1 << $urandom_range(0, 63),
				rand_bits($urandom_range(1, 16)) << $urandom_range(0, 47),
				64'd1 << $urandom_range(0, 63));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_overflow();
		test_zero_products();
		test_reducible(350);
		sender_idles = 1'b0;
		test_equal_fractions(100);
		sender_idles = 1'b1;
		test_full_width(200);
		test_mixed_lengths(150);
		sender_idles = 1'b0;
		test_reducible(100);
		sender_idles = 1'b1;
		test_powers_of_two(50);

		start <= 1'b0;
		while (pending_quotients.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d operand sets sent, %0d quotients checked, %0d of them reduced to 64 bits",
			sets_sent, quotients_seen, reduced_seen);
		$display("%0d errors, %0d quotients still pending", errors, pending_quotients.size());
		if (errors == 0 && pending_quotients.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
